// File: src/wvm_pkg.sv
// shared constants, codes and types for the wavetable voice mixer
`default_nettype none

package wvm_pkg;

    // sample memory and field widths
    localparam int ADDR_W       = 16;
    localparam int SAMPLE_BYTES = 1 << ADDR_W;
    localparam int POS_W        = 27;
    localparam int LEN_W        = 17;
    localparam int STEP_W       = 12;
    localparam int VOL_W        = 7;
    localparam int BYTE_W       = 8;
    localparam int OUT_W        = 16;
    localparam int KIND_W       = 2;
    localparam int VSEL_W       = 2;

    // position fixed point
    localparam int FRACTION_BITS = 10;
    localparam int EXT_W        = (LEN_W + FRACTION_BITS > POS_W) ? LEN_W + FRACTION_BITS : POS_W;

    // gain arithmetic: (master * volume * byte) / 64
    localparam int GAIN_W       = 2 * VOL_W;
    localparam int PROD_W       = GAIN_W + 1 + BYTE_W;
    localparam int DIV_SHIFT    = 6;
    localparam int DIV_MASK     = (1 << DIV_SHIFT) - 1;

    // loop end must be above this to loop
    localparam int LOOP_MIN     = 2;

    localparam int DEF_VOICES   = 4;
    localparam logic [VOL_W-1:0] MASTER_RESET = VOL_W'(64);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MIX  = 2'd2;

    // per-voice settings
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  loop_end;
        logic [LEN_W-1:0]  loop_len;
        logic [STEP_W-1:0] step;
        logic [VOL_W-1:0]  volume;
        logic              enabled;
    } voice_cfg_t;

    // position unit result for one voice
    typedef struct packed {
        logic              active;
        logic              sound;
        logic [POS_W-1:0]  pos_adj;
        logic [ADDR_W-1:0] addr;
    } pos_calc_t;

endpackage

`default_nettype wire

// File: src/wvm_pos_calc.sv
// loop wrap, one-shot end check and sample address for one voice
`default_nettype none

module wvm_pos_calc
    import wvm_pkg::*;
(
    input  voice_cfg_t       cfg,
    input  logic [POS_W-1:0] pos,
    output pos_calc_t        res
);

    logic             looping;
    logic [EXT_W-1:0] pos_e;
    logic [EXT_W-1:0] lend_e;
    logic [EXT_W-1:0] llen_e;
    logic [EXT_W-1:0] len_e;
    logic [EXT_W-1:0] pos_w;

    assign looping = (cfg.loop_end > LEN_W'(LOOP_MIN));
    assign pos_e   = EXT_W'(pos);
    assign lend_e  = EXT_W'(cfg.loop_end) << FRACTION_BITS;
    assign llen_e  = EXT_W'(cfg.loop_len) << FRACTION_BITS;
    assign len_e   = EXT_W'(cfg.length) << FRACTION_BITS;

    // wrap back by the loop length once the loop end is reached
    always_comb
    begin
        pos_w = pos_e;
        if (looping && (pos_e >= lend_e))
        begin
            pos_w = (pos_e >= llen_e) ? (pos_e - llen_e) : '0;
        end
    end

    // one-shot voice is silent at or beyond its length
    assign res.active  = cfg.enabled && (cfg.length != '0);
    assign res.sound   = looping || (pos_e < len_e);
    assign res.pos_adj = pos_w[POS_W-1:0];
    assign res.addr    = cfg.base + ADDR_W'(pos_w[POS_W-1:0] >> FRACTION_BITS);

endmodule

`default_nettype wire

// File: src/wavetable_voice_mixer.sv
// wavetable voice mixer top level: sample memory, voice state and mix sequencer
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  in       | in_valid / in_stall     | kind voice address byte_value ... enable
//  out      | out_valid / out_stall   | left_sample right_sample
//  cfg      | cfg_valid / cfg_ready   | cfg_data (master volume)
//
// load and set-voice transactions leave the block idle and ready for the next item.
// a mix takes each voice in turn through position unit, multiply and accumulate, then
// hands off the frame; silent or disabled voices skip multiply and accumulate.
// the shared position unit and multiply path set the pace.
// reset clears all voice state and sets master volume to 64; sample memory is not cleared.
// a stalled frame waits in the output register; a finished mix waits for it to drain.
`default_nettype none

module wavetable_voice_mixer
    import wvm_pkg::*;
#(
    parameter int VOICES = DEF_VOICES
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    // item channel
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire [KIND_W-1:0]          kind,
    input  wire [VSEL_W-1:0]          voice,
    input  wire [ADDR_W-1:0]          address,
    input  wire signed [BYTE_W-1:0]   byte_value,
    input  wire [LEN_W-1:0]           sample_length,
    input  wire [LEN_W-1:0]           loop_end,
    input  wire [LEN_W-1:0]           loop_length,
    input  wire [STEP_W-1:0]          step,
    input  wire [VOL_W-1:0]           volume,
    input  wire [POS_W-1:0]           position,
    input  wire                       set_position,
    input  wire                       enable,
    // frame channel
    output logic                      out_valid,
    input  wire                       out_stall,
    output logic signed [OUT_W-1:0]   left_sample,
    output logic signed [OUT_W-1:0]   right_sample,
    // master volume write channel
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire [VOL_W-1:0]           cfg_data
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [VIDX_W-1:0]          vidx_reg, vidx_next;
    logic [VOL_W-1:0]           master_reg;
    voice_cfg_t                 cfg_reg [VOICES];
    logic [POS_W-1:0]           pos_reg [VOICES];
    logic [BYTE_W-1:0]          sample_mem [SAMPLE_BYTES];

    pos_calc_t                  calc_res;
    pos_calc_t                  calc_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [BYTE_W-1:0]   rdata_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [OUT_W-1:0]    left_acc_reg, right_acc_reg;
    logic                       out_valid_reg;
    logic signed [OUT_W-1:0]    left_out_reg, right_out_reg;

    voice_cfg_t                 cfg_cur;
    logic [POS_W-1:0]           pos_cur;
    logic                       in_acc;
    logic                       set_ok;
    logic [VIDX_W-1:0]          set_idx;
    logic                       vidx_last;
    logic [1:0]                 vidx_ext;
    logic                       side_left;
    logic                       out_free;
    logic signed [PROD_W-1:0]   prod_bias;
    logic signed [PROD_W-1:0]   quot;
    logic signed [OUT_W-1:0]    contrib;
    logic [POS_W:0]             adv_sum;
    logic [POS_W-1:0]           pos_adv;

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_sample  = left_out_reg;
    assign right_sample = right_out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // voice selection
    assign set_ok    = (int'(voice) < VOICES);
    assign set_idx   = VIDX_W'(voice);
    assign vidx_last = (vidx_reg == VIDX_W'(VOICES - 1));
    assign vidx_ext  = 2'(vidx_reg);
    assign side_left = (vidx_ext[0] == vidx_ext[1]);
    assign cfg_cur   = cfg_reg[vidx_reg];
    assign pos_cur   = pos_reg[vidx_reg];

    // shared position unit
    wvm_pos_calc u_pos_calc (
        .cfg (cfg_cur),
        .pos (pos_cur),
        .res (calc_res)
    );

    // truncating divide by 64 of the product
    assign prod_bias = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(DIV_MASK) : '0);
    assign quot      = prod_bias >>> DIV_SHIFT;
    assign contrib   = quot[OUT_W-1:0];

    // saturating position advance
    assign adv_sum = {1'b0, calc_reg.pos_adj} + (POS_W + 1)'(cfg_cur.step);
    assign pos_adv = adv_sum[POS_W] ? '1 : adv_sum[POS_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (kind == KIND_MIX))
                begin
                    state_next = S_CALC;
                    vidx_next  = '0;
                end
            end
            S_CALC:
            begin
                if (calc_res.active && calc_res.sound)
                begin
                    state_next = S_MUL;
                end
                else if (vidx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (vidx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CALC;
                    vidx_next  = vidx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
        end
    end

    // master volume register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= MASTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            master_reg <= cfg_data;
        end
    end

    // voice settings and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                cfg_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_acc && (kind == KIND_SET) && set_ok)
            begin
                cfg_reg[set_idx].base     <= address;
                cfg_reg[set_idx].length   <= sample_length;
                cfg_reg[set_idx].loop_end <= loop_end;
                cfg_reg[set_idx].loop_len <= loop_length;
                cfg_reg[set_idx].step     <= step;
                cfg_reg[set_idx].volume   <= volume;
                cfg_reg[set_idx].enabled  <= enable;
                if (set_position)
                begin
                    pos_reg[set_idx] <= position;
                end
            end
            if (state_reg == S_ACC)
            begin
                pos_reg[vidx_reg] <= pos_adv;
            end
        end
    end

    // sample memory: load writes, registered read
    always_ff @(posedge clk)
    begin
        if (in_acc && (kind == KIND_LOAD))
        begin
            sample_mem[address] <= byte_value;
        end
        rdata_reg <= sample_mem[calc_res.addr];
    end

    // shared gain and multiply datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            calc_reg <= calc_res;
            gain_reg <= GAIN_W'(master_reg) * GAIN_W'(cfg_cur.volume);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(signed'({1'b0, gain_reg})) * PROD_W'(rdata_reg);
        end
    end

    // channel accumulators
    always_ff @(posedge clk)
    begin
        if (in_acc && (kind == KIND_MIX))
        begin
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            if (side_left)
            begin
                left_acc_reg <= left_acc_reg + contrib;
            end
            else
            begin
                right_acc_reg <= right_acc_reg + contrib;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            left_out_reg  <= left_acc_reg;
            right_out_reg <= right_acc_reg;
        end
    end

endmodule

`default_nettype wire

// File: src/wvm_checker.sv
// port-level checks for the wavetable voice mixer, bound to the top level
`default_nettype none

module wvm_checker
    import wvm_pkg::*;
(
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_stall,
    input wire [KIND_W-1:0]        kind,
    input wire                     out_valid,
    input wire                     out_stall,
    input wire signed [OUT_W-1:0]  left_sample,
    input wire signed [OUT_W-1:0]  right_sample
);

    // stalled frame holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(left_sample) && $stable(right_sample))
    else $error("stalled frame changed");

    // a mix transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_MIX) |=> in_stall)
    else $error("mix did not occupy the block");

    // load, set and unknown transactions leave the block ready for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != KIND_MIX) |=> !in_stall)
    else $error("non-mix transaction held the block");

    // only a mix produces a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != KIND_MIX) && !out_valid |=> !out_valid)
    else $error("frame appeared without a mix");

endmodule

bind wavetable_voice_mixer wvm_checker u_wvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample)
);

`default_nettype wire
